### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/mkd_pkg.sv
// shared constants, types and the morse lookup table for the key decoder
// no dependencies
`default_nettype none

package mkd_pkg;

    localparam int MAX_SYMBOLS = 5;
    localparam int SYM_W       = MAX_SYMBOLS;
    localparam int COUNT_W     = $clog2(MAX_SYMBOLS + 1);

    localparam int MS_W        = 16;
    localparam int KIND_W      = 3;
    localparam int CHAR_W      = 7;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // register index taken from paddr[2]
    localparam logic REG_DOT_LIMIT  = 1'b0;
    localparam logic REG_DASH_LIMIT = 1'b1;

    localparam logic [MS_W-1:0] DOT_LIMIT_RESET  = 16'd400;
    localparam logic [MS_W-1:0] DASH_LIMIT_RESET = 16'd800;

    localparam logic [KIND_W-1:0] KIND_DOT       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DASH      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CHAR      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd4;

    typedef struct packed {
        logic [MS_W-1:0] dot_limit;
        logic [MS_W-1:0] dash_limit;
    } cfg_t;

    // pattern bit i is symbol i, 1 = dash; returns 0 when no letter or digit matches
    function automatic logic [CHAR_W-1:0] morse_lookup(
        input logic [SYM_W-1:0]   bits,
        input logic [COUNT_W-1:0] count
    );
        logic [CHAR_W-1:0] ch;
        ch = '0;
        case (count)
            COUNT_W'(1):
            begin
                case (bits[0])
                    1'b0:    ch = 7'h65; // e
                    1'b1:    ch = 7'h74; // t
                    default: ch = '0;
                endcase
            end
            COUNT_W'(2):
            begin
                case (bits[1:0])
                    2'b10:   ch = 7'h61; // a
                    2'b00:   ch = 7'h69; // i
                    2'b11:   ch = 7'h6d; // m
                    2'b01:   ch = 7'h6e; // n
                    default: ch = '0;
                endcase
            end
            COUNT_W'(3):
            begin
                case (bits[2:0])
                    3'b001:  ch = 7'h64; // d
                    3'b011:  ch = 7'h67; // g
                    3'b101:  ch = 7'h6b; // k
                    3'b111:  ch = 7'h6f; // o
                    3'b010:  ch = 7'h72; // r
                    3'b000:  ch = 7'h73; // s
                    3'b100:  ch = 7'h75; // u
                    3'b110:  ch = 7'h77; // w
                    default: ch = '0;
                endcase
            end
            COUNT_W'(4):
            begin
                case (bits[3:0])
                    4'b0001: ch = 7'h62; // b
                    4'b0101: ch = 7'h63; // c
                    4'b0100: ch = 7'h66; // f
                    4'b0000: ch = 7'h68; // h
                    4'b1110: ch = 7'h6a; // j
                    4'b0010: ch = 7'h6c; // l
                    4'b0110: ch = 7'h70; // p
                    4'b1011: ch = 7'h71; // q
                    4'b1000: ch = 7'h76; // v
                    4'b1001: ch = 7'h78; // x
                    4'b1101: ch = 7'h79; // y
                    4'b0011: ch = 7'h7a; // z
                    default: ch = '0;
                endcase
            end
            COUNT_W'(5):
            begin
                case (bits[4:0])
                    5'b11111: ch = 7'h30;
                    5'b11110: ch = 7'h31;
                    5'b11100: ch = 7'h32;
                    5'b11000: ch = 7'h33;
                    5'b10000: ch = 7'h34;
                    5'b00000: ch = 7'h35;
                    5'b00001: ch = 7'h36;
                    5'b00011: ch = 7'h37;
                    5'b00111: ch = 7'h38;
                    5'b01111: ch = 7'h39;
                    default:  ch = '0;
                endcase
            end
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mkd_cfg_regs.sv
// apb register file holding the dot and dash duration limits
// depends on mkd_pkg
`default_nettype none

module mkd_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mkd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [mkd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [mkd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output mkd_pkg::cfg_t                         cfg
);

    logic [mkd_pkg::MS_W-1:0] dot_limit_reg;
    logic [mkd_pkg::MS_W-1:0] dash_limit_reg;
    logic                     wr_en;
    logic                     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    // word-aligned decode, low address bits ignored
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_limit_reg  <= mkd_pkg::DOT_LIMIT_RESET;
            dash_limit_reg <= mkd_pkg::DASH_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                mkd_pkg::REG_DOT_LIMIT:  dot_limit_reg  <= pwdata[mkd_pkg::MS_W-1:0];
                mkd_pkg::REG_DASH_LIMIT: dash_limit_reg <= pwdata[mkd_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            mkd_pkg::REG_DOT_LIMIT:
                prdata = mkd_pkg::APB_DATA_W'(dot_limit_reg);
            mkd_pkg::REG_DASH_LIMIT:
                prdata = mkd_pkg::APB_DATA_W'(dash_limit_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.dot_limit  = dot_limit_reg;
    assign cfg.dash_limit = dash_limit_reg;

endmodule

`default_nettype wire

### hw/rtl/morse_key_decoder_unit.sv
// morse key decoder: timed key presses in, symbol and character events out
// depends on mkd_pkg and mkd_cfg_regs
//
// input channel: in_valid / in_stall carrying press_ms, one key press per request
// output channel: out_valid / out_stall carrying kind and character, exactly one
//   result per accepted press, in order
// a press at or above dash_limit looks up the stored pattern and clears it; else a
//   full pattern gives full and is cleared, below dot_limit adds a dot, else a dash
// results go to the output register, or the skid register on a stall; throughput:
//   one press per cycle while in_stall is low; classification, pattern update and
//   the table lookup all sit between the pattern register and the output register
// when out_stall holds a result, one more press is taken into a skid register and
//   in_stall then rises until the output register drains; pready is always high
// reset clears the pattern and both output valid flags; limits return to 400 / 800
// the user writes limits over the apb port only while the block is idle, unenforced
`default_nettype none

module morse_key_decoder_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mkd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [mkd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [mkd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [mkd_pkg::MS_W-1:0]         press_ms,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [mkd_pkg::KIND_W-1:0]       kind,
    output logic      [mkd_pkg::CHAR_W-1:0]       character
);

    mkd_pkg::cfg_t cfg;

    logic [mkd_pkg::SYM_W-1:0]   bits_reg;
    logic [mkd_pkg::SYM_W-1:0]   bits_next;
    logic [mkd_pkg::COUNT_W-1:0] count_reg;
    logic [mkd_pkg::COUNT_W-1:0] count_next;

    logic                        out_valid_reg;
    logic [mkd_pkg::KIND_W-1:0]  out_kind_reg;
    logic [mkd_pkg::CHAR_W-1:0]  out_char_reg;
    logic                        skid_valid_reg;
    logic [mkd_pkg::KIND_W-1:0]  skid_kind_reg;
    logic [mkd_pkg::CHAR_W-1:0]  skid_char_reg;

    logic [mkd_pkg::KIND_W-1:0]  res_kind;
    logic [mkd_pkg::CHAR_W-1:0]  res_char;
    logic [mkd_pkg::CHAR_W-1:0]  found_char;

    logic in_accept;
    logic out_free;
    logic is_end;
    logic is_full;
    logic is_dot;

    mkd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    // output register can take a new request this cycle
    assign out_free  = !out_valid_reg || !out_stall;

    assign is_end     = press_ms >= cfg.dash_limit;
    assign is_full    = count_reg >= mkd_pkg::COUNT_W'(mkd_pkg::MAX_SYMBOLS);
    assign is_dot     = press_ms < cfg.dot_limit;
    assign found_char = mkd_pkg::morse_lookup(bits_reg, count_reg);

    always_comb
    begin
        bits_next  = bits_reg;
        count_next = count_reg;
        res_char   = '0;
        if (is_end)
        begin
            res_char   = found_char;
            res_kind   = (found_char != '0) ? mkd_pkg::KIND_CHAR : mkd_pkg::KIND_NOT_FOUND;
            bits_next  = '0;
            count_next = '0;
        end
        else if (is_full)
        begin
            res_kind   = mkd_pkg::KIND_FULL;
            bits_next  = '0;
            count_next = '0;
        end
        else
        begin
            res_kind = is_dot ? mkd_pkg::KIND_DOT : mkd_pkg::KIND_DASH;
            if (!is_dot)
            begin
                for (int i = 0; i < mkd_pkg::MAX_SYMBOLS; i++)
                begin
                    if (count_reg == mkd_pkg::COUNT_W'(i))
                    begin
                        bits_next[i] = 1'b1;
                    end
                end
            end
            count_next = count_reg + mkd_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                bits_reg  <= bits_next;
                count_reg <= count_next;
            end
            if (out_free)
            begin
                out_valid_reg  <= skid_valid_reg || in_accept;
                skid_valid_reg <= 1'b0;
            end
            else if (in_accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // payload stages, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_kind_reg <= skid_kind_reg;
                out_char_reg <= skid_char_reg;
            end
            else if (in_accept)
            begin
                out_kind_reg <= res_kind;
                out_char_reg <= res_char;
            end
        end
        else if (in_accept)
        begin
            skid_kind_reg <= res_kind;
            skid_char_reg <= res_char;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign character = out_char_reg;

endmodule

`default_nettype wire

### hw/rtl/mkd_checker.sv
// port-level checks for the morse key decoder, bound to the top level
// depends on mkd_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module mkd_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [mkd_pkg::KIND_W-1:0]    kind,
    input wire logic [mkd_pkg::CHAR_W-1:0]    character
);

    // the handshake outputs are quiet in the cycle after reset is seen low
    `CHK_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |=> !out_valid && !in_stall, "output active during reset")

    `CHK_ASSERT(a_kind_range, out_valid |-> kind <= mkd_pkg::KIND_FULL, "kind out of range")

    `CHK_ASSERT(a_char_only_on_decode, out_valid && kind != mkd_pkg::KIND_CHAR |-> character == '0, "character set without decode")

    `CHK_ASSERT(a_stall_needs_result, in_stall |-> out_valid, "input stalled with no result pending")

    `CHK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(kind) && $stable(character), "stalled result changed")

endmodule

bind morse_key_decoder_unit mkd_checker u_mkd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .character (character)
);

`default_nettype wire

### verif/morse_key_decoder_unit_test.sv
// self-checking testbench for morse_key_decoder_unit: timed key presses in, symbol events out
// depends on mkd_pkg and the decoder rtl; results are checked against
// an in-bench model of the pattern register and the morse table
`timescale 1ns / 1ps

module morse_key_decoder_unit_test;

    localparam int PHASE_ITEMS = 120;
    localparam int TABLE_SIZE  = 36;

    localparam logic [mkd_pkg::APB_ADDR_W-1:0] ADDR_DOT_LIMIT  =
        {mkd_pkg::REG_DOT_LIMIT, 2'b00};
    localparam logic [mkd_pkg::APB_ADDR_W-1:0] ADDR_DASH_LIMIT =
        {mkd_pkg::REG_DASH_LIMIT, 2'b00};

    typedef struct packed {
        logic [mkd_pkg::KIND_W-1:0] kind;
        logic [mkd_pkg::CHAR_W-1:0] character;
    } key_event_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [mkd_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [mkd_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [mkd_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [mkd_pkg::MS_W-1:0]       press_ms = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [mkd_pkg::KIND_W-1:0]     kind;
    logic [mkd_pkg::CHAR_W-1:0]     character;

    // bench copy of the limits and the pattern register
    logic [mkd_pkg::MS_W-1:0] dot_lim = mkd_pkg::DOT_LIMIT_RESET;
    logic [mkd_pkg::MS_W-1:0] dash_lim = mkd_pkg::DASH_LIMIT_RESET;
    logic [7:0]               pat_bits = '0;
    int                       pat_count = 0;

    logic [mkd_pkg::MS_W-1:0] press_queue [$];
    key_event_t               awaited_events [$];
    int                       mismatch_count = 0;

    string morse_codes [TABLE_SIZE] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..", "-----", ".----", "..---",
        "...--", "....-", ".....", "-....", "--...", "---..", "----."
    };
    string morse_letters = "abcdefghijklmnopqrstuvwxyz0123456789";

    morse_key_decoder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .press_ms  (press_ms),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .character (character)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // returns 0 when the pattern is no letter or digit
    function automatic logic [mkd_pkg::CHAR_W-1:0] decode_pattern(input logic [7:0] bits,
                                                                  input int count);
        string code;
        logic  hit;
        for (int k = 0; k < TABLE_SIZE; k++)
        begin
            code = morse_codes[k];
            if (code.len() == count)
            begin
                hit = 1'b1;
                for (int i = 0; i < count; i++)
                    if (bits[i] != (code[i] == "-"))
                        hit = 1'b0;
                if (hit)
                    return mkd_pkg::CHAR_W'(morse_letters[k]);
            end
        end
        return '0;
    endfunction

    task automatic classify_press(input logic [mkd_pkg::MS_W-1:0] p);
        key_event_t ev;
        ev.character = '0;
        if (p >= dash_lim)
        begin
            ev.character = decode_pattern(pat_bits, pat_count);
            ev.kind      = (ev.character != '0) ? mkd_pkg::KIND_CHAR : mkd_pkg::KIND_NOT_FOUND;
            pat_bits     = '0;
            pat_count    = 0;
        end
        else if (pat_count >= mkd_pkg::MAX_SYMBOLS)
        begin
            ev.kind   = mkd_pkg::KIND_FULL;
            pat_bits  = '0;
            pat_count = 0;
        end
        else
        begin
            if (p < dot_lim)
                ev.kind = mkd_pkg::KIND_DOT;
            else
            begin
                ev.kind            = mkd_pkg::KIND_DASH;
                pat_bits[pat_count] = 1'b1;
            end
            pat_count++;
        end
        awaited_events.push_back(ev);
    endtask

    // sender: bursts of random length with random gaps, payload held while stalled
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic                     next_valid;
        logic [mkd_pkg::MS_W-1:0] next_press;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            press_ms   <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            next_valid = in_valid;
            next_press = press_ms;
            if (in_valid && !in_stall)
                classify_press(press_ms);
            if (!(in_valid && in_stall))
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (press_queue.size() > 0)
                begin
                    next_valid = 1'b1;
                    next_press = press_queue.pop_front();
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 60);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            in_valid <= next_valid;
            press_ms <= next_press;
        end
    end

    // receiver stall pattern, with a long periodic hold-off
    int rx_cycle = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic hold;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_cycle  = 0;
        end
        else
        begin
            rx_cycle++;
            if ((rx_cycle % 1500) >= 1300)
                hold = 1'b1;
            else
            begin
                case ((rx_cycle / 200) % 4)
                    0:       hold = 1'b0;
                    1:       hold = ($urandom_range(0, 2) == 0);
                    2:       hold = rx_cycle[2];
                    default: hold = ($urandom_range(0, 3) != 0);
                endcase
            end
            out_stall <= hold;
        end
    end

    // result check against the oldest awaited event
    always @(posedge clk)
    begin
        key_event_t exp_ev;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_events.size() == 0)
            begin
                $error("unexpected result: kind %0d character %0d", kind, character);
                mismatch_count++;
            end
            else
            begin
                exp_ev = awaited_events.pop_front();
                if (kind !== exp_ev.kind)
                begin
                    $error("kind: expected %0d, actual %0d", exp_ev.kind, kind);
                    mismatch_count++;
                end
                if (character !== exp_ev.character)
                begin
                    $error("character: expected %0d, actual %0d", exp_ev.character, character);
                    mismatch_count++;
                end
            end
        end
    end

    // sampled away from the rising edge so driver updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (press_queue.size() != 0 || in_valid || awaited_events.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(input logic [mkd_pkg::APB_ADDR_W-1:0] addr,
                               input logic [mkd_pkg::MS_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom_range(0, 65535)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DOT_LIMIT)
            dot_lim = value;
        else
            dash_lim = value;
    endtask

    task automatic set_limits(input int dot_value, input int dash_value);
        wait_drained();
        write_limit(ADDR_DOT_LIMIT, mkd_pkg::MS_W'(dot_value));
        write_limit(ADDR_DASH_LIMIT, mkd_pkg::MS_W'(dash_value));
    endtask

    // boundary values come up often
    function automatic logic [mkd_pkg::MS_W-1:0] pick_range(input int lo, input int hi);
        if (hi < lo)
            return mkd_pkg::MS_W'(lo);
        case ($urandom_range(0, 5))
            0:       return mkd_pkg::MS_W'(lo);
            1:       return mkd_pkg::MS_W'(hi);
            default: return mkd_pkg::MS_W'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic logic [mkd_pkg::MS_W-1:0] dot_press();
        int top;
        top = (dot_lim < dash_lim) ? int'(dot_lim) : int'(dash_lim);
        return pick_range(0, top - 1);
    endfunction

    task automatic queue_pattern(input logic [7:0] bits, input int count, input bit with_end);
        for (int i = 0; i < count; i++)
            press_queue.push_back(bits[i] ? pick_range(dot_lim, int'(dash_lim) - 1) : dot_press());
        if (with_end)
            press_queue.push_back(pick_range(dash_lim, 65535));
    endtask

    task automatic queue_random(input int n);
        int         start;
        int         len;
        int         k;
        logic [7:0] bits;
        string      code;
        start = press_queue.size();
        while (press_queue.size() - start < n)
        begin
            case ($urandom_range(0, 9))
                7:  press_queue.push_back(mkd_pkg::MS_W'($urandom_range(0, 65535)));
                8:
                begin
                    // sequence left open, runs into the next one
                    bits = 8'($urandom_range(0, 255));
                    queue_pattern(bits, $urandom_range(1, mkd_pkg::MAX_SYMBOLS + 1), 1'b0);
                end
                9:
                begin
                    case ($urandom_range(0, 5))
                        0:       press_queue.push_back(dot_lim - 1'b1);
                        1:       press_queue.push_back(dot_lim);
                        2:       press_queue.push_back(dash_lim - 1'b1);
                        3:       press_queue.push_back(dash_lim);
                        4:       press_queue.push_back('0);
                        default: press_queue.push_back('1);
                    endcase
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        k    = $urandom_range(0, TABLE_SIZE - 1);
                        code = morse_codes[k];
                        len  = code.len();
                        bits = '0;
                        for (int i = 0; i < len; i++)
                            bits[i] = (code[i] == "-");
                    end
                    else
                    begin
                        len  = $urandom_range(0, mkd_pkg::MAX_SYMBOLS + 1);
                        bits = 8'($urandom_range(0, 255));
                    end
                    queue_pattern(bits, len, 1'b1);
                end
            endcase
        end
    endtask

    task automatic run_phase();
        queue_random(PHASE_ITEMS / 2);
        wait_drained();
        queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset limits 400 / 800
        press_queue.push_back(16'd800);             // end on empty pattern, exactly at limit
        press_queue.push_back(16'd0);
        press_queue.push_back(16'd65535);           // e
        press_queue.push_back(16'd399);
        press_queue.push_back(16'd400);
        press_queue.push_back(16'd800);             // a
        press_queue.push_back(16'd799);
        press_queue.push_back(16'd0);
        press_queue.push_back(16'd400);
        press_queue.push_back(16'd399);
        press_queue.push_back(16'd801);             // c
        press_queue.push_back(16'd400);
        press_queue.push_back(16'd500);
        press_queue.push_back(16'd600);
        press_queue.push_back(16'd700);
        press_queue.push_back(16'd799);
        press_queue.push_back(16'd65535);           // zero from five dashes, full pattern
        press_queue.push_back(16'd0);
        press_queue.push_back(16'd1);
        press_queue.push_back(16'd2);
        press_queue.push_back(16'd3);
        press_queue.push_back(16'd4);
        press_queue.push_back(16'd5);               // sixth symbol, buffer full
        press_queue.push_back(16'd800);             // pattern was cleared
        run_phase();

        set_limits(1, 65535);
        run_phase();
        set_limits(65535, 1);                       // crossed, no dash possible
        run_phase();
        set_limits(300, 300);
        run_phase();
        set_limits(0, 0);                           // every press ends the character
        run_phase();
        set_limits(0, 600);                         // no dots
        run_phase();
        set_limits($urandom_range(1, 2000), $urandom_range(1000, 4000));
        run_phase();
        set_limits($urandom_range(1, 65535), $urandom_range(1, 65535));
        run_phase();
        set_limits(400, 800);
        run_phase();

        wait_drained();
        repeat (5) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/mkd_pkg.sv
hw/rtl/mkd_cfg_regs.sv
hw/rtl/morse_key_decoder_unit.sv
hw/rtl/mkd_checker.sv
verif/morse_key_decoder_unit_test.sv
